FILE: src/dbh_pkg.sv
// ----------------------------------------------------------------------------
// dbh_pkg
// Shared types and constants for the debounce with hold duration block.
// ----------------------------------------------------------------------------
package dbh_pkg;

    localparam int MAX_CHANNELS = 12;
    localparam int TICK_W       = 8;
    localparam int STEPS_W      = 3;
    localparam int LEVELS_W     = MAX_CHANNELS;
    localparam int HOLDS_W      = MAX_CHANNELS * STEPS_W;

    localparam logic [STEPS_W-1:0] HOLD_MAX      = 3'b111;
    localparam logic [TICK_W-1:0]  STEP_QUARTERS = 8'd2;

    // per-channel state word kept in the state memory
    typedef struct packed {
        logic               armed;
        logic [TICK_W-1:0]  arm_time;
        logic               level;
        logic [STEPS_W-1:0] hold_steps;
        logic [TICK_W-1:0]  next_step_time;
    } t_entry;

endpackage

FILE: src/debounce_with_hold_duration.sv
// ----------------------------------------------------------------------------
// debounce_with_hold_duration
// Debounced active-low input bank with per-channel half-second hold counts.
//
// input channel: i_valid / o_ready carry one scan item (raw pin levels, 100 ms
//   tick, quarter-second tick). output channel: o_valid / i_ready carry one
//   result item per scan (changed flag, debounced levels, packed durations).
// per-channel state sits in a small memory; a sequencer walks the channels,
//   one read-modify-write per cycle while the pipeline advances, through a
//   read stage and an update stage; the result is written to the output
//   register when the last channel of the scan has been updated.
// the next scan is taken while the last channel of the current one is read,
//   so scans follow each other with no gap.
// reset (synchronous, active low) clears the written flags of the memory, so
//   every channel starts disarmed, off, with zero duration; no clearing pass.
// a stalled receiver holds the output register; the pipeline then freezes on
//   the last channel of the following scan and o_ready drops until it drains.
// ----------------------------------------------------------------------------
module debounce_with_hold_duration #(
    parameter int CHANNELS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [dbh_pkg::LEVELS_W-1:0]  i_raw_levels,
    input  logic [dbh_pkg::TICK_W-1:0]    i_tenth_tick,
    input  logic [dbh_pkg::TICK_W-1:0]    i_quarter_tick,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_changed,
    output logic [dbh_pkg::LEVELS_W-1:0]  o_levels,
    output logic [dbh_pkg::HOLDS_W-1:0]   o_hold_times
);
    import dbh_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

    // scan item held for the whole channel walk
    logic [LEVELS_W-1:0] r_in_raw;
    logic [TICK_W-1:0]   r_in_tenth;
    logic [TICK_W-1:0]   r_in_quarter;

    // read stage: channel address presented to the memory
    logic                r_iss_v;
    logic [CH_W-1:0]     r_ch;

    // update stage: read data back, channel updated and written
    logic                r_b_v;
    logic [CH_W-1:0]     r_b_ch;
    logic                r_b_pin;
    logic [TICK_W-1:0]   r_b_tenth;
    logic [TICK_W-1:0]   r_b_quarter;
    logic                b_last;

    // partial result of the scan being walked
    logic                r_acc_changed;
    logic [LEVELS_W-1:0] r_acc_levels;
    logic [HOLDS_W-1:0]  r_acc_holds;
    logic                n_acc_changed;
    logic [LEVELS_W-1:0] n_acc_levels;
    logic [HOLDS_W-1:0]  n_acc_holds;

    // output register
    logic                r_o_valid;
    logic                r_o_changed;
    logic [LEVELS_W-1:0] r_o_levels;
    logic [HOLDS_W-1:0]  r_o_holds;

    logic                advance;
    logic                accept;
    logic                finish;
    t_entry              rd_entry;
    logic                rd_written;
    t_entry              wr_entry;
    logic                ch_send;

    assign b_last = (r_b_ch == LAST_CH);

    // the whole pipeline freezes only when a finished scan cannot leave
    assign advance = !(r_b_v && b_last && r_o_valid && !i_ready);
    assign finish  = r_b_v && b_last && advance;
    assign o_ready = advance && (!r_iss_v || (r_ch == LAST_CH));
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_raw     <= i_raw_levels;
            r_in_tenth   <= i_tenth_tick;
            r_in_quarter <= i_quarter_tick;
        end
    end

    // channel sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_v <= 1'b0;
            r_ch    <= '0;
        end else if (advance) begin
            if (accept) begin
                r_iss_v <= 1'b1;
                r_ch    <= '0;
            end else if (r_iss_v) begin
                if (r_ch == LAST_CH) begin
                    r_iss_v <= 1'b0;
                end else begin
                    r_ch <= r_ch + CH_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (advance) begin
            r_b_v <= r_iss_v;
        end
    end

    // tick values travel with the channel so the next scan can load behind it
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_b_ch      <= r_ch;
            r_b_pin     <= r_in_raw[r_ch];
            r_b_tenth   <= r_in_tenth;
            r_b_quarter <= r_in_quarter;
        end
    end

    dbh_entry_mem #(
        .CHANNELS (CHANNELS),
        .CH_W     (CH_W)
    ) u_mem (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_en      (advance && r_iss_v),
        .i_rd_addr    (r_ch),
        .o_rd_data    (rd_entry),
        .o_rd_written (rd_written),
        .i_wr_en      (advance && r_b_v),
        .i_wr_addr    (r_b_ch),
        .i_wr_data    (wr_entry)
    );

    dbh_chan_update u_upd (
        .i_entry    (rd_entry),
        .i_written  (rd_written),
        .i_pin_high (r_b_pin),
        .i_tenth    (r_b_tenth),
        .i_quarter  (r_b_quarter),
        .o_entry    (wr_entry),
        .o_send     (ch_send)
    );

    // place this channel's level and duration; channel 0 opens a fresh result
    always_comb begin
        logic first;
        first         = (r_b_ch == '0);
        n_acc_changed = (first ? 1'b0 : r_acc_changed) | ch_send;
        n_acc_levels  = first ? '0 : r_acc_levels;
        n_acc_holds   = first ? '0 : r_acc_holds;
        for (int i = 0; i < CHANNELS; i++) begin
            if (r_b_ch == CH_W'(i)) begin
                n_acc_levels[LEVELS_W-1-i] = wr_entry.level;
                n_acc_holds[HOLDS_W-1-STEPS_W*i -: STEPS_W] = wr_entry.hold_steps;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_b_v) begin
            r_acc_changed <= n_acc_changed;
            r_acc_levels  <= n_acc_levels;
            r_acc_holds   <= n_acc_holds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (finish) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_o_changed <= n_acc_changed;
            r_o_levels  <= n_acc_levels;
            r_o_holds   <= n_acc_holds;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_changed    = r_o_changed;
    assign o_levels     = r_o_levels;
    assign o_hold_times = r_o_holds;

`ifndef NO_ASSERTIONS
    // channels of a scan reach the update stage in order, one per advance
    a_ch_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_v && advance && !b_last) |=> (r_b_v && r_b_ch == $past(r_b_ch) + CH_W'(1)))
        else $error("update stage skipped or repeated a channel");

    // a frozen update stage keeps its channel
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_v && !advance) |=> (r_b_v && $stable(r_b_ch)))
        else $error("update stage moved while stalled");

    // a finished scan never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |-> (!r_o_valid || i_ready))
        else $error("result register overwritten");

    // a new scan is taken only when the sequencer is free or on its last channel
    a_accept_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (!r_iss_v || r_ch == LAST_CH))
        else $error("scan accepted mid-walk");
`endif

endmodule

FILE: src/dbh_entry_mem.sv
// ----------------------------------------------------------------------------
// dbh_entry_mem
// Per-channel state memory, registered read, write-to-read bypass.
// ----------------------------------------------------------------------------
module dbh_entry_mem #(
    parameter int CHANNELS = 12,
    parameter int CH_W     = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [CH_W-1:0]       i_rd_addr,
    output dbh_pkg::t_entry       o_rd_data,
    output logic                  o_rd_written,
    input  logic                  i_wr_en,
    input  logic [CH_W-1:0]       i_wr_addr,
    input  dbh_pkg::t_entry       i_wr_data
);
    import dbh_pkg::*;

    t_entry              mem [CHANNELS];
    logic [CHANNELS-1:0] r_written;
    t_entry              r_rd_data;
    logic                r_rd_written;
    logic                bypass;

    // same entry written and read in one cycle: take the new word
    assign bypass = i_wr_en && (i_wr_addr == i_rd_addr);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= bypass ? i_wr_data : mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_written[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_written <= bypass || r_written[i_rd_addr];
            end
        end
    end

    assign o_rd_data    = r_rd_data;
    assign o_rd_written = r_rd_written;

endmodule

FILE: src/dbh_chan_update.sv
// ----------------------------------------------------------------------------
// dbh_chan_update
// Debounce and hold-step update of one channel's state word.
// ----------------------------------------------------------------------------
module dbh_chan_update (
    input  dbh_pkg::t_entry                 i_entry,
    input  logic                            i_written,
    input  logic                            i_pin_high,
    input  logic [dbh_pkg::TICK_W-1:0]      i_tenth,
    input  logic [dbh_pkg::TICK_W-1:0]      i_quarter,
    output dbh_pkg::t_entry                 o_entry,
    output logic                            o_send
);
    import dbh_pkg::*;

    t_entry            cur;
    t_entry            upd;
    logic              on;
    logic              send;
    logic [TICK_W-1:0] next_time;

    // never-written entries read as the reset state
    always_comb begin
        cur = i_entry;
        if (!i_written) begin
            cur.armed      = 1'b0;
            cur.level      = 1'b0;
            cur.hold_steps = '0;
        end
    end

    always_comb begin
        upd       = cur;
        send      = 1'b0;
        next_time = i_quarter + STEP_QUARTERS;

        if (i_pin_high) begin
            on        = 1'b0;
            upd.armed = 1'b0;
        end else if (!cur.armed) begin
            upd.armed    = 1'b1;
            upd.arm_time = i_tenth;
            on           = 1'b0;
        end else if (cur.level) begin
            on = 1'b1;
        end else begin
            on = (cur.arm_time != i_tenth);
        end

        if (!on) begin
            send           = cur.level;
            upd.level      = 1'b0;
            upd.hold_steps = '0;
        end else begin
            if (!cur.level) begin
                // turn-on: fresh duration, first step two quarters ahead
                upd.hold_steps     = '0;
                upd.level          = 1'b1;
                upd.next_step_time = next_time;
                send               = 1'b1;
            end else if (cur.next_step_time == i_quarter) begin
                upd.next_step_time = next_time;
                if (cur.hold_steps != HOLD_MAX) begin
                    upd.hold_steps = cur.hold_steps + STEPS_W'(1);
                end
                send = 1'b1;
            end
        end
    end

    assign o_entry = upd;
    assign o_send  = send;

endmodule
